### rtl/vra_pkg.sv
package vra_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;
    // power of two
    localparam int PAGE_BYTES_DEF    = 4096;

    localparam int ADDR_W  = 32;
    localparam int PAGES_W = 21;
    localparam int ENTRY_W = ADDR_W + PAGES_W;

    localparam logic [PAGES_W-1:0] PAGES_MAX = {PAGES_W{1'b1}};

    localparam logic REG_POOL_BASE = 1'b0;
    localparam logic REG_POOL_SIZE = 1'b1;

    typedef enum logic [1:0] {
        ACT_ALLOC   = 2'd0,
        ACT_RELEASE = 2'd1,
        ACT_CHECK   = 2'd2,
        ACT_IGNORE  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_ZERO_SIZE = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ARD,
        S_AMUL,
        S_AWR,
        S_SRCH,
        S_SHIFT
    } t_state;

    typedef struct packed {
        logic [ADDR_W-1:0] pool_base;
        logic [ADDR_W-1:0] pool_size;
    } t_cfg;

    typedef struct packed {
        logic [ADDR_W-1:0]  base;
        logic [PAGES_W-1:0] pages;
    } t_entry;

    typedef struct packed {
        t_status            status;
        logic [ADDR_W-1:0]  region_start;
        logic [PAGES_W-1:0] freed_pages;
        logic               legitimate;
    } t_result;

endpackage

### rtl/virtual_region_allocator.sv
// channel   direction  handshake                      payload
// request   in         start & !busy                  i_action, i_request_bytes, i_address
// result    out        o_done (one cycle, no stall)   o_status, o_region_start,
//                                                     o_freed_pages, o_legitimate
// config    in         psel & penable & pwrite        paddr, pwdata (prdata on read)
//
// check, zero-size and full-table allocate, and release on an empty table: result in the cycle after the request
// allocate: the result follows the last entry read, the multiply for its end, then the write
// release: a search of the table if not found; a search, then a shift of the later entries down, if found
// reset is synchronous and empties the table; the table memory itself is not cleared
// busy is registered state, high after an accepted request until the cycle before the result; the receiver cannot stall
module virtual_region_allocator
    import vra_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int PAGE_BYTES    = PAGE_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_action,
    input  logic [ADDR_W-1:0]  i_request_bytes,
    input  logic [ADDR_W-1:0]  i_address,
    output logic               o_done,
    output logic [1:0]         o_status,
    output logic [ADDR_W-1:0]  o_region_start,
    output logic [PAGES_W-1:0] o_freed_pages,
    output logic               o_legitimate,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    t_cfg             r_cfg;
    t_result          result;
    logic             cfg_wr;
    logic             re;
    logic             we;
    logic [IDX_W-1:0] raddr;
    logic [IDX_W-1:0] waddr;
    t_entry           rdata;
    t_entry           wdata;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_POOL_BASE: r_cfg.pool_base <= pwdata;
                REG_POOL_SIZE: r_cfg.pool_size <= pwdata;
                default:       r_cfg           <= r_cfg;
            endcase
        end
    end

    assign prdata = (paddr[2] == REG_POOL_SIZE) ? r_cfg.pool_size : r_cfg.pool_base;

    vra_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .PAGE_BYTES    (PAGE_BYTES)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_action        (i_action),
        .i_request_bytes (i_request_bytes),
        .i_address       (i_address),
        .i_cfg           (r_cfg),
        .o_busy          (busy),
        .o_done          (o_done),
        .o_result        (result),
        .o_re            (re),
        .o_raddr         (raddr),
        .i_rdata         (rdata),
        .o_we            (we),
        .o_waddr         (waddr),
        .o_wdata         (wdata)
    );

    vra_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign o_status       = result.status;
    assign o_region_start = result.region_start;
    assign o_freed_pages  = result.freed_pages;
    assign o_legitimate   = result.legitimate;

endmodule

### rtl/vra_ram.sv
module vra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/vra_ctrl.sv
module vra_ctrl
    import vra_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int PAGE_BYTES    = PAGE_BYTES_DEF,
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [1:0]         i_action,
    input  logic [ADDR_W-1:0]  i_request_bytes,
    input  logic [ADDR_W-1:0]  i_address,
    input  t_cfg               i_cfg,
    output logic               o_busy,
    output logic               o_done,
    output t_result            o_result,
    output logic               o_re,
    output logic [IDX_W-1:0]   o_raddr,
    input  t_entry             i_rdata,
    output logic               o_we,
    output logic [IDX_W-1:0]   o_waddr,
    output t_entry             o_wdata
);

    localparam int                SH      = $clog2(PAGE_BYTES);
    localparam logic [ADDR_W-1:0] PB_MASK = ADDR_W'(PAGE_BYTES - 1);
    localparam logic [ADDR_W-1:0] PB_A    = ADDR_W'(PAGE_BYTES);
    localparam logic [CNT_W-1:0]  FULL    = CNT_W'(TABLE_ENTRIES);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [CNT_W-1:0]   r_idx, n_idx;
    logic [CNT_W-1:0]   r_tag, n_tag;
    logic               r_tag_v, n_tag_v;
    logic [ADDR_W-1:0]  r_req, n_req;
    logic [ADDR_W-1:0]  r_addr, n_addr;
    logic [PAGES_W-1:0] r_pages, n_pages;
    logic [ADDR_W-1:0]  r_len, n_len;
    logic [ADDR_W-1:0]  r_base, n_base;
    logic               r_done, n_done;
    t_result            r_res, n_res;

    logic [ADDR_W:0]    pg_sum;
    logic [ADDR_W:0]    pool_hi;
    logic [ADDR_W-1:0]  start_addr;
    logic               issue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_tag_v <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_tag_v <= n_tag_v;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_tag   <= n_tag;
        r_req   <= n_req;
        r_addr  <= n_addr;
        r_pages <= n_pages;
        r_len   <= n_len;
        r_base  <= n_base;
        r_res   <= n_res;
    end

    always_comb begin
        pg_sum     = {1'b0, (r_req >> SH)} + (ADDR_W+1)'((r_req & PB_MASK) != '0);
        pool_hi    = {1'b0, i_cfg.pool_base} + {1'b0, i_cfg.pool_size};
        start_addr = (r_cnt == '0) ? i_cfg.pool_base + PB_A : r_base + r_len;
        issue      = (r_idx < r_cnt);
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_idx   = r_idx;
        n_tag   = r_tag;
        n_tag_v = 1'b0;
        n_req   = r_req;
        n_addr  = r_addr;
        n_pages = r_pages;
        n_len   = r_len;
        n_base  = r_base;
        n_done  = 1'b0;
        n_res   = r_res;
        o_re    = 1'b0;
        o_raddr = r_idx[IDX_W-1:0];
        o_we    = 1'b0;
        o_waddr = r_cnt[IDX_W-1:0];
        o_wdata = i_rdata;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_req   = i_request_bytes;
                    n_addr  = i_address;
                    n_idx   = '0;
                    n_res   = '0;
                    unique case (t_action'(i_action))
                        ACT_ALLOC: begin
                            if (i_request_bytes == '0) begin
                                n_res.status = ST_ZERO_SIZE;
                                n_done       = 1'b1;
                            end else if (r_cnt == FULL) begin
                                n_res.status = ST_FULL;
                                n_done       = 1'b1;
                            end else begin
                                n_state = S_ARD;
                            end
                        end
                        ACT_RELEASE: begin
                            n_res.region_start = i_address;
                            if (r_cnt == '0) begin
                                n_res.status = ST_NOT_FOUND;
                                n_done       = 1'b1;
                            end else begin
                                n_state = S_SRCH;
                            end
                        end
                        ACT_CHECK: begin
                            n_res.legitimate = (i_address >= i_cfg.pool_base) &&
                                               ({1'b0, i_address} < pool_hi);
                            n_done           = 1'b1;
                        end
                        ACT_IGNORE: begin
                            n_state = S_IDLE;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            S_ARD: begin
                n_pages = (pg_sum > (ADDR_W+1)'(PAGES_MAX)) ? PAGES_MAX
                                                          : pg_sum[PAGES_W-1:0];
                o_re    = (r_cnt != '0);
                o_raddr = IDX_W'(r_cnt - 1'b1);
                n_state = S_AMUL;
            end

            S_AMUL: begin
                n_len   = {{(ADDR_W-PAGES_W){1'b0}}, i_rdata.pages} * PB_A;
                n_base  = i_rdata.base;
                n_state = S_AWR;
            end

            S_AWR: begin
                o_we               = 1'b1;
                o_waddr            = r_cnt[IDX_W-1:0];
                o_wdata.base       = start_addr;
                o_wdata.pages      = r_pages;
                n_cnt              = r_cnt + 1'b1;
                n_res.status       = ST_OK;
                n_res.region_start = start_addr;
                n_done             = 1'b1;
                n_state            = S_IDLE;
            end

            // reads issued back to back, each compare in the cycle after its read
            S_SRCH: begin
                o_re    = issue;
                o_raddr = r_idx[IDX_W-1:0];
                if (issue) begin
                    n_idx   = r_idx + 1'b1;
                    n_tag   = r_idx;
                    n_tag_v = 1'b1;
                end
                if (r_tag_v) begin
                    if (i_rdata.base == r_addr) begin
                        n_pages = i_rdata.pages;
                        n_idx   = r_tag + 1'b1;
                        n_tag_v = 1'b0;
                        n_state = S_SHIFT;
                    end else if (r_tag == CNT_W'(r_cnt - 1'b1)) begin
                        n_res.status = ST_NOT_FOUND;
                        n_done       = 1'b1;
                        n_tag_v      = 1'b0;
                        n_state      = S_IDLE;
                    end
                end
            end

            // move later entries down by one
            S_SHIFT: begin
                o_re    = issue;
                o_raddr = r_idx[IDX_W-1:0];
                if (issue) begin
                    n_idx   = r_idx + 1'b1;
                    n_tag   = r_idx;
                    n_tag_v = 1'b1;
                end
                if (r_tag_v) begin
                    o_we    = 1'b1;
                    o_waddr = IDX_W'(r_tag - 1'b1);
                    o_wdata = i_rdata;
                end
                if (!issue && !r_tag_v) begin
                    n_cnt             = r_cnt - 1'b1;
                    n_res.status      = ST_OK;
                    n_res.freed_pages = r_pages;
                    n_done            = 1'b1;
                    n_state           = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_res;

endmodule
